/* sv/spd_pkg.sv */
// Package: shared constants, codes and the queue entry type for the supremum distance block
package spd_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int PW            = FRACTION_BITS + 1;
    localparam int SW            = FRACTION_BITS + 2;
    localparam int DENW          = 2 * FRACTION_BITS + 1;
    localparam int NUMW          = 4 * FRACTION_BITS + 3;
    localparam int QW            = 2 * FRACTION_BITS + 3;
    localparam int CNTW          = $clog2(NUMW + 1);

    localparam logic [1:0] MODE_PHI = 2'd0;
    localparam logic [1:0] MODE_KSI = 2'd1;
    localparam logic [1:0] MODE_KS  = 2'd2;

    localparam logic [1:0] KIND_SKIP  = 2'd0;
    localparam logic [1:0] KIND_PLAIN = 2'd1;
    localparam logic [1:0] KIND_PHI   = 2'd2;
    localparam logic [1:0] KIND_KSI   = 2'd3;

    typedef struct packed {
        logic [PW-1:0] diff;
        logic [SW-1:0] sum;
        logic [SW-1:0] rest;
        logic [1:0]    kind;
        logic          last;
    } t_entry;

endpackage

/* sv/spd_in_if.sv */
// Interface: input channel carrying one probability pair per transfer
interface spd_in_if;
    logic                  valid;
    logic                  ready;
    logic [spd_pkg::PW-1:0] first_prob;
    logic [spd_pkg::PW-1:0] second_prob;
    logic                  last_element;

    modport source (output valid, output first_prob, output second_prob,
                    output last_element, input ready);
    modport sink   (input valid, input first_prob, input second_prob,
                    input last_element, output ready);
endinterface

/* sv/spd_out_if.sv */
// Interface: output channel carrying one supremum distance per transfer
interface spd_out_if;
    logic                  valid;
    logic                  ready;
    logic [spd_pkg::SW-1:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

/* sv/spd_front.sv */
// Front: clamps and classifies an input pair into a queue entry
module spd_front (
    spd_in_if.sink         i_in,
    input  logic [1:0]     i_mode,
    input  logic           i_full,
    output logic           o_push,
    output spd_pkg::t_entry o_entry
);
    import spd_pkg::*;

    localparam logic [PW-1:0] ONE = PW'(1) << FRACTION_BITS;
    localparam logic [SW-1:0] TWO = SW'(1) << (FRACTION_BITS + 1);

    logic [PW-1:0] r_c;
    logic [PW-1:0] w_c;
    logic [SW-1:0] sum;
    logic [SW-1:0] rest;

    assign r_c  = (i_in.first_prob  > ONE) ? ONE : i_in.first_prob;
    assign w_c  = (i_in.second_prob > ONE) ? ONE : i_in.second_prob;
    assign sum  = SW'(r_c) + SW'(w_c);
    assign rest = TWO - sum;

    assign i_in.ready = ~i_full;
    assign o_push     = i_in.valid & ~i_full;

    always_comb begin
        o_entry.diff = (r_c > w_c) ? (r_c - w_c) : (w_c - r_c);
        o_entry.sum  = sum;
        o_entry.rest = rest;
        o_entry.last = i_in.last_element;
        unique case (i_mode) inside
            MODE_PHI, MODE_KSI: begin
                if (sum == '0 || rest == '0) begin
                    o_entry.kind = KIND_SKIP;
                end else begin
                    o_entry.kind = (i_mode == MODE_PHI) ? KIND_PHI : KIND_KSI;
                end
            end
            default: o_entry.kind = KIND_PLAIN;
        endcase
    end
endmodule

/* sv/spd_queue.sv */
// Queue: two-entry buffer between front and back
module spd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  spd_pkg::t_entry i_entry,
    input  logic            i_pop,
    output spd_pkg::t_entry o_entry,
    output logic            o_empty,
    output logic            o_full
);
    import spd_pkg::*;

    t_entry     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_entry = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

/* sv/spd_back.sv */
// Back: scores entries (by division and square root in phi and ksi modes), keeps the supremum, emits results
module spd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spd_pkg::t_entry i_entry,
    input  logic            i_empty,
    output logic            o_pop,
    spd_out_if.source       o_out
);
    import spd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;

    localparam logic [QW-1:0] CAPSQ = QW'(1) << (2 * FRACTION_BITS + 2);

    logic [2:0]      r_state, n_state;
    logic [PW-1:0]   r_diff, n_diff;
    logic [SW-1:0]   r_sum, n_sum;
    logic [SW-1:0]   r_rest, n_rest;
    logic [1:0]      r_kind, n_kind;
    logic            r_last, n_last;
    logic [NUMW-1:0] r_num, n_num;
    logic [DENW-1:0] r_den, n_den;
    logic [DENW-1:0] r_rem, n_rem;
    logic [QW-1:0]   r_quo, n_quo;
    logic            r_ovf, n_ovf;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [SW-1:0]   r_root, n_root;
    logic [SW-1:0]   r_score, n_score;
    logic            r_use, n_use;
    logic [SW-1:0]   r_sup, n_sup;
    logic            r_out_valid, n_out_valid;
    logic [SW-1:0]   r_out_data, n_out_data;

    logic [2*PW-1:0] sq;
    logic [2*SW-1:0] st;
    logic [DENW:0]   rem_sh;
    logic            ge;
    logic [QW-1:0]   qcap;
    logic [SW-1:0]   cand;
    logic [2*SW-1:0] csq;
    logic [SW-1:0]   new_sup;

    assign o_out.valid    = r_out_valid;
    assign o_out.distance = r_out_data;

    assign sq      = r_diff * r_diff;
    assign st      = r_sum * r_rest;
    assign rem_sh  = {r_rem, r_num[NUMW-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign qcap    = (r_ovf || r_quo > CAPSQ) ? CAPSQ : r_quo;
    assign cand    = r_root | (SW'(1) << (r_cnt - CNTW'(1)));
    assign csq     = cand * cand;
    assign new_sup = (r_use && r_score > r_sup) ? r_score : r_sup;

    always_comb begin
        n_state     = r_state;
        n_diff      = r_diff;
        n_sum       = r_sum;
        n_rest      = r_rest;
        n_kind      = r_kind;
        n_last      = r_last;
        n_num       = r_num;
        n_den       = r_den;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_ovf       = r_ovf;
        n_cnt       = r_cnt;
        n_root      = r_root;
        n_score     = r_score;
        n_use       = r_use;
        n_sup       = r_sup;
        n_out_valid = r_out_valid & ~o_out.ready;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_diff = i_entry.diff;
                    n_sum  = i_entry.sum;
                    n_rest = i_entry.rest;
                    n_kind = i_entry.kind;
                    n_last = i_entry.last;
                    case (i_entry.kind)
                        KIND_SKIP: begin
                            n_use   = 1'b0;
                            n_score = '0;
                            n_state = S_ACC;
                        end
                        KIND_PLAIN: begin
                            n_use   = 1'b1;
                            n_score = SW'(i_entry.diff);
                            n_state = S_ACC;
                        end
                        default: begin
                            n_use   = 1'b1;
                            n_state = S_MUL;
                        end
                    endcase
                end
            end
            S_MUL: begin
                if (r_kind == KIND_PHI) begin
                    n_num = NUMW'(sq) << (FRACTION_BITS + 1);
                    n_den = DENW'((r_sum < r_rest) ? r_sum : r_rest);
                end else begin
                    n_num = NUMW'(sq) << (2 * FRACTION_BITS + 2);
                    n_den = st[DENW-1:0];
                end
                n_rem   = '0;
                n_quo   = '0;
                n_ovf   = 1'b0;
                n_cnt   = CNTW'(NUMW);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = ge ? DENW'(rem_sh - {1'b0, r_den}) : DENW'(rem_sh);
                n_quo = {r_quo[QW-2:0], ge};
                n_ovf = r_ovf | r_quo[QW-1];
                n_num = r_num << 1;
                n_cnt = r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    n_root  = '0;
                    n_cnt   = CNTW'(SW);
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (csq <= (2*SW)'(qcap)) begin
                    n_root = cand;
                end
                n_cnt = r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    n_score = (csq <= (2*SW)'(qcap)) ? cand : r_root;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (!(r_last && r_out_valid && !o_out.ready)) begin
                    if (r_last) begin
                        n_out_data  = new_sup;
                        n_out_valid = 1'b1;
                        n_sup       = '0;
                    end else begin
                        n_sup = new_sup;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_diff     <= n_diff;
        r_sum      <= n_sum;
        r_rest     <= n_rest;
        r_kind     <= n_kind;
        r_last     <= n_last;
        r_num      <= n_num;
        r_den      <= n_den;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_ovf      <= n_ovf;
        r_cnt      <= n_cnt;
        r_root     <= n_root;
        r_score    <= n_score;
        r_use      <= n_use;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sup       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sup       <= n_sup;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

/* sv/sup_probability_distance.sv */
// Top level: weighted supremum distance between two probability vectors
//
//  channel  | dir | payload                                    | marks a transfer
//  i_in     | in  | first_prob, second_prob, last_element      | valid & ready
//  o_out    | out | distance                                   | valid & ready
//  i_cfg_*  | in  | metric_mode                                | i_cfg_we
//
// Plain mode: the back part takes an item through S_IDLE and S_ACC. Phi and ksi: an item
// goes through S_MUL, the 67-step restoring divider, the 18-step root search and S_ACC.
// A pair skipped for degenerate mean goes from S_IDLE straight to S_ACC.
// The two-entry queue lets the front take items while the back works.
// Reset is synchronous; it clears the queue, the supremum and the output stage.
// A result waits in the output register while o_out.ready is low.
module sup_probability_distance (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    spd_in_if.sink     i_in,
    spd_out_if.source  o_out
);
    import spd_pkg::*;

    logic   [1:0] r_mode;
    logic         push;
    logic         pop;
    logic         full;
    logic         empty;
    t_entry       in_entry;
    t_entry       head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PHI;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    spd_front u_front (
        .i_in    (i_in),
        .i_mode  (r_mode),
        .i_full  (full),
        .o_push  (push),
        .o_entry (in_entry)
    );

    spd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (in_entry),
        .i_pop   (pop),
        .o_entry (head),
        .o_empty (empty),
        .o_full  (full)
    );

    spd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule

/* sv/spd_checker.sv */
// Checker: port-level assertions on the supremum distance block, bound to the top level
module spd_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [spd_pkg::SW-1:0] i_distance
);
    import spd_pkg::*;

    localparam logic [SW-1:0] TWO = SW'(1) << (FRACTION_BITS + 1);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_distance <= TWO)
        else $error("distance above two");
endmodule

bind sup_probability_distance spd_checker u_spd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_distance  (o_out.distance)
);
